// ----- rtl/core/ccp_pkg.sv -----
// Shared types and constants for the three-point circumcircle datapath.
package ccp_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int NUM_W = 58;
    localparam int DEN_W = 34;
    localparam int QUO_W = 32;
    localparam int SQRT_STEPS = 32;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [31:0]        sa;
        logic signed [34:0] det;
        logic signed [50:0] nx;
        logic signed [50:0] ny;
        logic               col;
    } ccp_item_t;

endpackage

// ----- rtl/core/ccp_front.sv -----
// Front end: bisector terms, determinant and numerators, collinear classification.
module ccp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                ready,
    input  logic signed [15:0]  first_x,
    input  logic signed [15:0]  first_y,
    input  logic signed [15:0]  second_x,
    input  logic signed [15:0]  second_y,
    input  logic signed [15:0]  third_x,
    input  logic signed [15:0]  third_y,
    input  logic                full,
    output logic                push,
    output ccp_pkg::ccp_item_t  item
);

    logic               en;
    logic [4:0]         v_reg;
    logic [4:0]         v_next;

    logic signed [15:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg;
    logic signed [15:0] ax4_reg, ay4_reg, ax5_reg, ay5_reg;
    logic signed [16:0] u1_reg, w1_reg, u2_reg, w2_reg;
    logic signed [16:0] u1b_reg, w1b_reg, u2b_reg, w2b_reg;
    logic signed [16:0] u1c_reg, w1c_reg, u2c_reg, w2c_reg;
    logic signed [31:0] sqax_reg, sqay_reg, sqbx_reg, sqby_reg, sqqx_reg, sqqy_reg;
    logic [31:0]        sa2_reg, sb_reg, sq_reg, sa3_reg, sa4_reg, sa5_reg;
    logic signed [33:0] p1_reg, p2_reg;
    logic signed [32:0] k1_reg, k2_reg;
    logic signed [34:0] det3_reg, det4_reg, det5_reg;
    logic signed [49:0] kw1_reg, kw2_reg, uk1_reg, uk2_reg;
    logic               col4_reg, col5_reg;
    logic signed [50:0] nx_reg, ny_reg;

    assign en    = !v_reg[4] || !full;
    assign ready = en;
    assign push  = v_reg[4] && !full;

    assign v_next = {v_reg[3:0], valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: differences and squares
            ax1_reg  <= first_x;
            ay1_reg  <= first_y;
            u1_reg   <= 17'(first_x) - 17'(second_x);
            w1_reg   <= 17'(first_y) - 17'(second_y);
            u2_reg   <= 17'(first_x) - 17'(third_x);
            w2_reg   <= 17'(first_y) - 17'(third_y);
            sqax_reg <= 32'(first_x) * 32'(first_x);
            sqay_reg <= 32'(first_y) * 32'(first_y);
            sqbx_reg <= 32'(second_x) * 32'(second_x);
            sqby_reg <= 32'(second_y) * 32'(second_y);
            sqqx_reg <= 32'(third_x) * 32'(third_x);
            sqqy_reg <= 32'(third_y) * 32'(third_y);
            // stage 2: norms and determinant products
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            u1b_reg  <= u1_reg;
            w1b_reg  <= w1_reg;
            u2b_reg  <= u2_reg;
            w2b_reg  <= w2_reg;
            sa2_reg  <= 32'(sqax_reg) + 32'(sqay_reg);
            sb_reg   <= 32'(sqbx_reg) + 32'(sqby_reg);
            sq_reg   <= 32'(sqqx_reg) + 32'(sqqy_reg);
            p1_reg   <= 34'(u1_reg) * 34'(w2_reg);
            p2_reg   <= 34'(u2_reg) * 34'(w1_reg);
            // stage 3: right-hand sides and determinant
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            sa3_reg  <= sa2_reg;
            u1c_reg  <= u1b_reg;
            w1c_reg  <= w1b_reg;
            u2c_reg  <= u2b_reg;
            w2c_reg  <= w2b_reg;
            k1_reg   <= $signed({1'b0, sa2_reg}) - $signed({1'b0, sb_reg});
            k2_reg   <= $signed({1'b0, sa2_reg}) - $signed({1'b0, sq_reg});
            det3_reg <= 35'(p1_reg) - 35'(p2_reg);
            // stage 4: Cramer numerator products
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
            sa4_reg  <= sa3_reg;
            det4_reg <= det3_reg;
            col4_reg <= (det3_reg == '0);
            kw1_reg  <= 50'(k1_reg) * 50'(w2c_reg);
            kw2_reg  <= 50'(k2_reg) * 50'(w1c_reg);
            uk1_reg  <= 50'(u1c_reg) * 50'(k2_reg);
            uk2_reg  <= 50'(u2c_reg) * 50'(k1_reg);
            // stage 5: numerators
            ax5_reg  <= ax4_reg;
            ay5_reg  <= ay4_reg;
            sa5_reg  <= sa4_reg;
            det5_reg <= det4_reg;
            col5_reg <= col4_reg;
            nx_reg   <= 51'(kw1_reg) - 51'(kw2_reg);
            ny_reg   <= 51'(uk1_reg) - 51'(uk2_reg);
        end
    end

    always_comb
    begin
        item.ax  = ax5_reg;
        item.ay  = ay5_reg;
        item.sa  = sa5_reg;
        item.det = det5_reg;
        item.nx  = nx_reg;
        item.ny  = ny_reg;
        item.col = col5_reg;
    end

endmodule

// ----- rtl/core/ccp_queue.sv -----
// Short FIFO between front end and back end.
module ccp_queue #(
    parameter int DEPTH = ccp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ccp_pkg::ccp_item_t push_item,
    input  logic               pop,
    output logic               full,
    output logic               nonempty,
    output ccp_pkg::ccp_item_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ccp_pkg::ccp_item_t mem_reg [0:DEPTH-1];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign head     = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/ccp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with quotient overflow flag.
module ccp_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [ccp_pkg::NUM_W-1:0]  num,
    input  logic [ccp_pkg::DEN_W-1:0]  den,
    output logic [ccp_pkg::QUO_W-1:0]  quo,
    output logic                       ovf
);

    localparam int NW = ccp_pkg::NUM_W;
    localparam int DW = ccp_pkg::DEN_W;
    localparam int QW = ccp_pkg::QUO_W;
    localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [NW-1:0] rem_reg [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic [QW-1:0] quo_reg [0:QW];
    logic          ovf_reg [0:QW];

    logic [NW-1:0] rem_next [0:QW-1];
    logic [QW-1:0] quo_next [0:QW-1];
    logic [CW-1:0] trial    [0:QW-1];

    always_comb
    begin
        for (int s = 0; s < QW; s++)
        begin
            trial[s]    = CW'(den_reg[s]) << (QW - 1 - s);
            rem_next[s] = rem_reg[s];
            quo_next[s] = quo_reg[s];
            if (CW'(rem_reg[s]) >= trial[s])
            begin
                rem_next[s] = rem_reg[s] - NW'(trial[s]);
                quo_next[s] = quo_reg[s] | (QW'(1) << (QW - 1 - s));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            ovf_reg[0] <= (CW'(num) >= (CW'(den) << QW));
            for (int s = 0; s < QW; s++)
            begin
                rem_reg[s+1] <= rem_next[s];
                den_reg[s+1] <= den_reg[s];
                quo_reg[s+1] <= quo_next[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

// ----- rtl/core/ccp_back.sv -----
// Back end: centre division, clipping, radius square root and constant term.
module ccp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ccp_pkg::ccp_item_t  item,
    output logic                pop,
    output logic                valid,
    input  logic                ready,
    output logic signed [31:0]  center_x,
    output logic signed [31:0]  center_y,
    output logic [31:0]         radius,
    output logic signed [63:0]  const_term,
    output logic                collinear,
    output logic                saturated
);

    localparam int NW      = ccp_pkg::NUM_W;
    localparam int DW      = ccp_pkg::DEN_W;
    localparam int QW      = ccp_pkg::QUO_W;
    localparam int SS      = ccp_pkg::SQRT_STEPS;
    localparam int DIV_LAT = QW + 1;
    localparam int LAT     = DIV_LAT + SS + 5;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [31:0]        sa;
        logic               negx;
        logic               negy;
        logic               col;
    } side_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [63:0]        pe;
        logic               sat;
        logic               ovr;
        logic               col;
    } sq_side_t;

    logic           en;
    logic [LAT-1:0] vld_reg, vld_next;

    logic [50:0]    nxm, nym;
    logic [DW-1:0]  dmag;
    logic [NW-1:0]  numx, numy;
    logic [QW-1:0]  qx, qy;
    logic           ovfx, ovfy;

    side_t          side_reg [0:QW];

    logic signed [31:0] cx_next, cy_next;
    logic               satx, saty;

    logic signed [31:0] cx_reg, cy_reg, cx1_reg, cy1_reg, cx2_reg, cy2_reg;
    logic [31:0]        sa_c_reg, sa1_reg, sa2_reg;
    logic               sat_c_reg, sat1_reg, sat2_reg, col_c_reg, col1_reg, col2_reg;
    logic signed [15:0] ax_c_reg, ay_c_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [47:0] pa_reg, pb_reg;
    logic [32:0]        mx, my;
    logic [63:0]        sx_reg, sy_reg;
    logic signed [48:0] ps_reg;
    logic [64:0]        dsum;
    logic [48:0]        psm;
    logic [49:0]        rsum;
    logic [63:0]        rq;
    logic [63:0]        pe_next;

    logic [63:0]        v_reg    [0:SS];
    logic [33:0]        rem_reg  [0:SS];
    logic [31:0]        root_reg [0:SS];
    sq_side_t           ss_reg   [0:SS];
    logic [33:0]        rem_cat  [0:SS-1];
    logic [33:0]        rtrial   [0:SS-1];
    logic [33:0]        rem_next [0:SS-1];
    logic [31:0]        root_next[0:SS-1];

    logic signed [31:0] cx_out_reg, cy_out_reg;
    logic [31:0]        rad_out_reg;
    logic [63:0]        pe_out_reg;
    logic               col_out_reg, sat_out_reg;

    function automatic logic [32:0] clip_q(input logic [31:0] q, input logic ovf,
                                           input logic neg);
        logic [32:0] r;
        if (neg)
        begin
            if (ovf || (q > 32'h8000_0000))
            begin
                r = {1'b1, 32'h8000_0000};
            end
            else
            begin
                r = {1'b0, 32'(32'd0 - q)};
            end
        end
        else
        begin
            if (ovf || q[31])
            begin
                r = {1'b1, 32'h7FFF_FFFF};
            end
            else
            begin
                r = {1'b0, q};
            end
        end
        return r;
    endfunction

    assign en       = !vld_reg[LAT-1] || ready;
    assign pop      = en && in_valid;
    assign valid    = vld_reg[LAT-1];
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // rounding dividend prep: |n|*128 + |det|/2 over |det|
    always_comb
    begin
        nxm  = item.nx[50] ? 51'(-item.nx) : 51'(item.nx);
        nym  = item.ny[50] ? 51'(-item.ny) : 51'(item.ny);
        dmag = item.det[34] ? DW'(-item.det) : DW'(item.det);
        numx = NW'({nxm, 7'b0}) + NW'(dmag[DW-1:1]);
        numy = NW'({nym, 7'b0}) + NW'(dmag[DW-1:1]);
    end

    ccp_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (numx),
        .den (dmag),
        .quo (qx),
        .ovf (ovfx)
    );

    ccp_div u_div_y (
        .clk (clk),
        .en  (en),
        .num (numy),
        .den (dmag),
        .quo (qy),
        .ovf (ovfy)
    );

    always_comb
    begin
        {satx, cx_next} = clip_q(qx, ovfx, side_reg[QW].negx);
        {saty, cy_next} = clip_q(qy, ovfy, side_reg[QW].negy);
        mx   = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        my   = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        dsum = 65'(sx_reg) + 65'(sy_reg);
        psm  = ps_reg[48] ? 49'(-ps_reg) : 49'(ps_reg);
        rsum = 50'(psm) + 50'd64;
        rq   = 64'(rsum[49:7]);
        pe_next = (ps_reg[48] ? (64'd0 - rq) : rq) - 64'(sa2_reg);
    end

    always_comb
    begin
        for (int s = 0; s < SS; s++)
        begin
            rem_cat[s]   = {rem_reg[s][31:0], v_reg[s][63:62]};
            rtrial[s]    = {root_reg[s], 2'b01};
            rem_next[s]  = rem_cat[s];
            root_next[s] = {root_reg[s][30:0], 1'b0};
            if (rem_cat[s] >= rtrial[s])
            begin
                rem_next[s]  = rem_cat[s] - rtrial[s];
                root_next[s] = {root_reg[s][30:0], 1'b1};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].ax   <= item.ax;
            side_reg[0].ay   <= item.ay;
            side_reg[0].sa   <= item.sa;
            side_reg[0].negx <= item.nx[50] ^ item.det[34];
            side_reg[0].negy <= item.ny[50] ^ item.det[34];
            side_reg[0].col  <= item.col;
            for (int s = 0; s < QW; s++)
            begin
                side_reg[s+1] <= side_reg[s];
            end

            // clip
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            sat_c_reg <= satx || saty;
            col_c_reg <= side_reg[QW].col;
            sa_c_reg  <= side_reg[QW].sa;
            ax_c_reg  <= side_reg[QW].ax;
            ay_c_reg  <= side_reg[QW].ay;

            // offsets and dot products
            dx_reg   <= 33'($signed({ax_c_reg, 8'b0})) - 33'(cx_reg);
            dy_reg   <= 33'($signed({ay_c_reg, 8'b0})) - 33'(cy_reg);
            pa_reg   <= 48'(ax_c_reg) * 48'(cx_reg);
            pb_reg   <= 48'(ay_c_reg) * 48'(cy_reg);
            cx1_reg  <= cx_reg;
            cy1_reg  <= cy_reg;
            sa1_reg  <= sa_c_reg;
            sat1_reg <= sat_c_reg;
            col1_reg <= col_c_reg;

            // squares
            sx_reg   <= 64'(66'(mx) * 66'(mx));
            sy_reg   <= 64'(66'(my) * 66'(my));
            ps_reg   <= 49'(pa_reg) + 49'(pb_reg);
            cx2_reg  <= cx1_reg;
            cy2_reg  <= cy1_reg;
            sa2_reg  <= sa1_reg;
            sat2_reg <= sat1_reg;
            col2_reg <= col1_reg;

            // square root entry
            v_reg[0]     <= dsum[63:0];
            rem_reg[0]   <= '0;
            root_reg[0]  <= '0;
            ss_reg[0].cx  <= cx2_reg;
            ss_reg[0].cy  <= cy2_reg;
            ss_reg[0].pe  <= pe_next;
            ss_reg[0].sat <= sat2_reg;
            ss_reg[0].ovr <= dsum[64];
            ss_reg[0].col <= col2_reg;
            for (int s = 0; s < SS; s++)
            begin
                v_reg[s+1]    <= {v_reg[s][61:0], 2'b00};
                rem_reg[s+1]  <= rem_next[s];
                root_reg[s+1] <= root_next[s];
                ss_reg[s+1]   <= ss_reg[s];
            end

            // result
            if (ss_reg[SS].col)
            begin
                cx_out_reg  <= '0;
                cy_out_reg  <= '0;
                rad_out_reg <= '0;
                pe_out_reg  <= '0;
                col_out_reg <= 1'b1;
                sat_out_reg <= 1'b0;
            end
            else
            begin
                cx_out_reg  <= ss_reg[SS].cx;
                cy_out_reg  <= ss_reg[SS].cy;
                rad_out_reg <= ss_reg[SS].ovr ? 32'hFFFF_FFFF : root_reg[SS];
                pe_out_reg  <= ss_reg[SS].pe;
                col_out_reg <= 1'b0;
                sat_out_reg <= ss_reg[SS].sat || ss_reg[SS].ovr;
            end
        end
    end

    assign center_x   = cx_out_reg;
    assign center_y   = cy_out_reg;
    assign radius     = rad_out_reg;
    assign const_term = $signed(pe_out_reg);
    assign collinear  = col_out_reg;
    assign saturated  = sat_out_reg;

endmodule

// ----- rtl/core/circumcircle_three_points.sv -----
// Top level: circle through three Q8.8 points, centre/radius in Q16.16.
// Pipeline: 5 front stages, the queue, 33 divider stages, 4 arithmetic stages,
// 32 square-root stages and 1 output register.
// Throughput: one transaction per cycle, set by the fully pipelined dividers and root;
// a low circle_ready stalls the back end and, once the queue fills, the front end.
// Reset: rst_n clears all valid bits and queue pointers; no clearing pass.
module circumcircle_three_points #(
    parameter int QUEUE_DEPTH = ccp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                point_valid,
    output logic                point_ready,
    input  logic signed [15:0]  first_x,
    input  logic signed [15:0]  first_y,
    input  logic signed [15:0]  second_x,
    input  logic signed [15:0]  second_y,
    input  logic signed [15:0]  third_x,
    input  logic signed [15:0]  third_y,
    output logic                circle_valid,
    input  logic                circle_ready,
    output logic signed [31:0]  center_x,
    output logic signed [31:0]  center_y,
    output logic [31:0]         radius,
    output logic signed [63:0]  const_term,
    output logic                collinear,
    output logic                saturated
);

    logic               push, full, nonempty, pop;
    ccp_pkg::ccp_item_t front_item, head_item;

    ccp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (point_valid),
        .ready    (point_ready),
        .first_x  (first_x),
        .first_y  (first_y),
        .second_x (second_x),
        .second_y (second_y),
        .third_x  (third_x),
        .third_y  (third_y),
        .full     (full),
        .push     (push),
        .item     (front_item)
    );

    ccp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .full      (full),
        .nonempty  (nonempty),
        .head      (head_item)
    );

    ccp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (nonempty),
        .item       (head_item),
        .pop        (pop),
        .valid      (circle_valid),
        .ready      (circle_ready),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .const_term (const_term),
        .collinear  (collinear),
        .saturated  (saturated)
    );

endmodule

// ----- tb/tb_circumcircle_three_points.sv -----
// Self-checking testbench for the three-point circumcircle block.
`timescale 1ns / 1ps

module tb_circumcircle_three_points;

    typedef struct {
        logic signed [15:0] fx, fy, sx, sy, tx, ty;
    } triple_t;

    typedef struct {
        logic [31:0] cx, cy, rad;
        logic [63:0] e;
        logic        col, sat;
    } circle_t;

    logic               clk;
    logic               rst_n;
    logic               point_valid;
    logic               point_ready;
    logic signed [15:0] first_x, first_y, second_x, second_y, third_x, third_y;
    logic               circle_valid;
    logic               circle_ready;
    logic signed [31:0] center_x, center_y;
    logic [31:0]        radius;
    logic signed [63:0] const_term;
    logic               collinear, saturated;

    triple_t pending_points[$];
    circle_t expected_circles[$];
    int      errors;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_cycles;
    int      quiet_cycles;
    bit      hold_req;
    bit      hold_done;

    circumcircle_three_points i_dut (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_ready(point_ready),
        .first_x(first_x), .first_y(first_y), .second_x(second_x),
        .second_y(second_y), .third_x(third_x), .third_y(third_y),
        .circle_valid(circle_valid), .circle_ready(circle_ready),
        .center_x(center_x), .center_y(center_y), .radius(radius),
        .const_term(const_term), .collinear(collinear), .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // nearest quotient, ties away from zero
    function automatic logic signed [127:0] round_div(logic signed [127:0] num,
                                                      logic signed [127:0] den);
        logic signed [127:0] n, d, q;
        n = num;
        d = den;
        if (d < 0)
        begin
            d = -d;
            n = -n;
        end
        if (n < 0)
        begin
            q = (-n + d / 2) / d;
            return -q;
        end
        q = (n + d / 2) / d;
        return q;
    endfunction

    function automatic logic signed [127:0] clamp32(logic signed [127:0] v, ref bit sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1;
            return 128'sd2147483647;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1;
            return -128'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [127:0] v);
        logic [127:0] r;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            if ((r | (128'd1 << b)) * (r | (128'd1 << b)) <= v)
                r = r | (128'd1 << b);
        end
        return r[63:0];
    endfunction

    function automatic circle_t predict_circle(triple_t p);
        logic signed [127:0] ax, ay, bx, by, qx, qy, u1, w1, u2, w2, k1, k2, det;
        logic signed [127:0] cx, cy, dx, dy, pe;
        logic [127:0]        dist2;
        logic [63:0]         root;
        bit                  sat;
        circle_t             c;
        ax = p.fx; ay = p.fy; bx = p.sx; by = p.sy; qx = p.tx; qy = p.ty;
        sat = 0;
        c = '{default: '0};
        u1 = ax - bx; w1 = ay - by;
        u2 = ax - qx; w2 = ay - qy;
        k1 = (ax * ax + ay * ay) - (bx * bx + by * by);
        k2 = (ax * ax + ay * ay) - (qx * qx + qy * qy);
        det = u1 * w2 - u2 * w1;
        if (det == 0)
        begin
            c.col = 1'b1;
            return c;
        end
        cx = clamp32(round_div((k1 * w2 - k2 * w1) * 128, det), sat);
        cy = clamp32(round_div((u1 * k2 - u2 * k1) * 128, det), sat);
        dx = ax * 256 - cx;
        dy = ay * 256 - cy;
        dist2 = dx * dx + dy * dy;
        if (dist2 >= (128'd1 << 64))
        begin
            c.rad = 32'hFFFF_FFFF;
            sat = 1;
        end
        else
        begin
            root = floor_sqrt(dist2);
            c.rad = root[31:0];
        end
        pe = round_div(ax * cx + ay * cy, 128) - (ax * ax + ay * ay);
        c.cx = cx[31:0];
        c.cy = cy[31:0];
        c.e = pe[63:0];
        c.sat = sat;
        return c;
    endfunction

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            default: return $signed(16'($urandom_range(0, 255))) - 16'sd128;
        endcase
    endfunction

    task automatic add_points(logic signed [15:0] a, b, c, d, e, f);
        triple_t p;
        p = '{a, b, c, d, e, f};
        pending_points.push_back(p);
    endtask

    task automatic add_random(int n);
        triple_t p;
        int      k;
        for (int i = 0; i < n; i++)
        begin
            p = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord()};
            k = $urandom_range(0, 19);
            if (k == 0)
            begin
                p.sx = p.fx; p.sy = p.fy;
            end
            else if (k == 1)
            begin
                // collinear: third = first + 2*(second - first) when it fits
                p.fx = $signed(16'($urandom_range(0, 511))) - 16'sd256;
                p.fy = $signed(16'($urandom_range(0, 511))) - 16'sd256;
                p.sx = p.fx + $signed(16'($urandom_range(0, 63))) - 16'sd32;
                p.sy = p.fy + $signed(16'($urandom_range(0, 63))) - 16'sd32;
                p.tx = 16'(2 * p.sx - p.fx);
                p.ty = 16'(2 * p.sy - p.fy);
            end
            else if (k == 2)
            begin
                // nearly collinear, drives the centre far out
                p.tx = p.sx + (p.sx - p.fx);
                p.ty = p.sy + (p.sy - p.fy) + 16'sd1;
            end
            pending_points.push_back(p);
        end
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || point_valid || expected_circles.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_valid <= 1'b0;
            {first_x, first_y, second_x, second_y, third_x, third_y} <= '0;
        end
        else
        begin
            if (point_valid && point_ready)
                expected_circles.push_back(predict_circle('{first_x, first_y, second_x,
                                                           second_y, third_x, third_y}));
            if (!point_valid || point_ready)
            begin
                if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    triple_t p;
                    p = pending_points.pop_front();
                    point_valid <= 1'b1;
                    first_x <= p.fx; first_y <= p.fy;
                    second_x <= p.sx; second_y <= p.sy;
                    third_x <= p.tx; third_y <= p.ty;
                end
                else
                    point_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circle_ready <= 1'b0;
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_cycles <= 300;
            hold_done <= 1'b1;
            circle_ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            circle_ready <= 1'b0;
        end
        else
            circle_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && circle_valid && circle_ready)
        begin
            if (expected_circles.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected circle transaction");
            end
            else
            begin
                circle_t x;
                x = expected_circles.pop_front();
                if (x.cx !== center_x || x.cy !== center_y || x.rad !== radius ||
                    x.e !== const_term || x.col !== collinear || x.sat !== saturated)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %h %h %h %h %b %b got %h %h %h %h %b %b",
                                 x.cx, x.cy, x.rad, x.e, x.col, x.sat, center_x,
                                 center_y, radius, const_term, collinear, saturated);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (point_valid && point_ready) || (circle_valid && circle_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        add_points(16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0100);
        add_points(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000);
        add_points(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000);
        add_points(16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100, 16'sh0200, 16'sh0300);
        add_points(16'sh0000, 16'sh0000, 16'sh0100, 16'sh0100, 16'sh0200, 16'sh0200);
        add_points(16'sh0005, 16'sh0005, 16'sh0005, 16'sh0005, 16'sh0005, 16'sh0005);
        add_points(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFE, 16'sh7FFF);
        add_points(16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0001);
        add_points(16'sh0000, 16'sh0000, 16'sh0003, 16'sh0000, 16'sh0000, 16'sh0003);
        add_points(16'shFFFF, 16'sh0000, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0001);
        add_points(16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh7FFF, 16'sh0001);
        add_points(16'sh8000, 16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh7FFF);
        add_points(16'sh1234, 16'shEDCB, 16'sh5555, 16'shAAAA, 16'shA5A5, 16'sh5A5A);
        add_random(5);
        wait_drained();

        add_random(110);
        wait_drained();

        send_idle_pct = 66;
        add_random(100);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 66;
        add_random(100);
        wait_drained();

        send_idle_pct = 12;
        recv_stall_pct = 12;
        add_random(120);
        @(posedge clk);
        hold_req = 1'b1;
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_random(60);
        wait_drained();

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
